@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define QTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define QTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/qtt_pkg.sv @@
// shared types and constants for the query timeout table
// no dependencies; used by qtt_cell and query_timeout_table_core
package qtt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_EXPIRE = 2'd3;

    typedef struct packed {
        logic [63:0] id;
        logic [3:0]  kind;
        logic [63:0] start;
        logic [31:0] timeout;
    } qtt_entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift;
        logic load;
    } qtt_cell_ctrl_t;

endpackage

@@ rtl/core/qtt_cell.sv @@
// one table slot: loads a word when addressed, else takes its upper neighbor on shift
// depends on qtt_pkg
module qtt_cell
    import qtt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX = 0,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  logic           clk,
    input  qtt_cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0] ptr,
    input  qtt_entry_t     load_data,
    input  qtt_entry_t     nbr,
    output qtt_entry_t     entry
);

    qtt_entry_t entry_reg;
    qtt_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load && (ptr == IDX_W'(IDX)))
        begin
            entry_next = load_data;
        end
        else if (ctrl.shift)
        begin
            entry_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/core/query_timeout_table_core.sv @@
// query timeout table top level: control sequencer plus a row of table cells
// depends on qtt_pkg, qtt_cell and assert_macros.svh
//
// usage: drive func and the operand ports with start high; the word is taken
// at a rising edge where start is high and busy is low. busy stays high while
// a scan runs; start is ignored then.
// insert appends at the tail (refused when full) and shows its result in the next cycle.
// lookup, remove and expire rotate the whole table once through the head cell:
// each cycle every cell takes its upper neighbor and the head word is either
// written back at the tail or dropped, so survivors keep their order. on an
// empty table these skip the scan and show their result in the next cycle.
// the expiry check (65-bit add and compare) sits on the head cell only.
// the result is shown for one cycle with done high; the receiver cannot stall,
// and a new word may be started in the same cycle that done is high.
// reset empties the table at once (count_reg to zero, no clearing pass);
// table contents are left as they are and only written entries are read.
module query_timeout_table_core
    import qtt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        func,
    input  logic [63:0]       req_id,
    input  logic [3:0]        query_kind,
    input  logic [63:0]       start_ms,
    input  logic [31:0]       limit_ms,
    input  logic [63:0]       now_ms,
    output logic              done,
    output logic              ok,
    output logic [3:0]        found_kind,
    output logic [63:0]       found_start_ms,
    output logic [31:0]       found_limit_ms,
    output logic [CNT_W-1:0]  purged_count,
    output logic [CNT_W-1:0]  entry_count
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t st_reg, st_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             hit_reg, hit_next;
    logic             done_reg, done_next;
    logic [1:0]       op_reg, op_next;
    logic [63:0]      key_reg, key_next;
    logic [63:0]      now_reg, now_next;

    logic             ok_reg, ok_next;
    logic [3:0]       fkind_reg, fkind_next;
    logic [63:0]      fstart_reg, fstart_next;
    logic [31:0]      ftime_reg, ftime_next;
    logic [CNT_W-1:0] expc_reg, expc_next;
    logic [CNT_W-1:0] entc_reg, entc_next;

    qtt_entry_t       cell_q [TABLE_DEPTH];
    qtt_entry_t       head;
    qtt_entry_t       in_entry;
    qtt_entry_t       load_data;
    qtt_cell_ctrl_t   cell_ctrl;
    logic [IDX_W-1:0] ptr;
    logic [CNT_W-1:0] count_m1;
    logic [64:0]      deadline;
    logic             id_hit;
    logic             exp_hit;
    logic             first_hit;
    logic             drop;
    logic             word_take;
    logic [CNT_W:0]   reply_total;

    // row of cells
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        qtt_entry_t nbr;
        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign nbr = cell_q[g];
        end
        else
        begin : g_mid
            assign nbr = cell_q[g + 1];
        end

        qtt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .ptr       (ptr),
            .load_data (load_data),
            .nbr       (nbr),
            .entry     (cell_q[g])
        );
    end

    assign head = cell_q[0];

    always_comb
    begin
        in_entry.id      = req_id;
        in_entry.kind    = query_kind;
        in_entry.start   = start_ms;
        in_entry.timeout = limit_ms;
    end

    assign load_data = (st_reg == ST_SCAN) ? head : in_entry;
    assign count_m1  = count_reg - CNT_W'(1);

    // head cell checks; deadline carry out means it never expires
    assign deadline  = {1'b0, head.start} + {33'd0, head.timeout};
    assign exp_hit   = {1'b0, now_reg} > deadline;
    assign id_hit    = (head.id == key_reg);
    assign first_hit = !hit_reg && id_hit;

    always_comb
    begin
        unique case (op_reg)
            FUNC_INSERT: drop = 1'b0;
            FUNC_LOOKUP: drop = 1'b0;
            FUNC_REMOVE: drop = first_hit;
            FUNC_EXPIRE: drop = exp_hit;
            default:     drop = 1'b0;
        endcase
    end

    always_comb
    begin
        st_next     = st_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        hit_next    = hit_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        key_next    = key_reg;
        now_next    = now_reg;
        ok_next     = ok_reg;
        fkind_next  = fkind_reg;
        fstart_next = fstart_reg;
        ftime_next  = ftime_reg;
        expc_next   = expc_reg;
        entc_next   = entc_reg;
        cell_ctrl   = '0;
        ptr         = count_reg[IDX_W-1:0];

        unique case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = func;
                    key_next    = req_id;
                    now_next    = now_ms;
                    hit_next    = 1'b0;
                    left_next   = count_reg;
                    fkind_next  = '0;
                    fstart_next = '0;
                    ftime_next  = '0;
                    expc_next   = '0;
                    entc_next   = count_reg;
                    ok_next     = 1'b0;
                    if (func == FUNC_INSERT)
                    begin
                        done_next = 1'b1;
                        if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            cell_ctrl.load = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                            entc_next      = count_reg + CNT_W'(1);
                            ok_next        = 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                        ok_next   = (func == FUNC_EXPIRE);
                    end
                    else
                    begin
                        st_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // every cell takes its neighbor; kept head word goes to the new tail
                cell_ctrl.shift = 1'b1;
                cell_ctrl.load  = !drop;
                ptr             = count_m1[IDX_W-1:0];
                count_next      = drop ? count_m1 : count_reg;
                left_next       = left_reg - CNT_W'(1);
                if (first_hit && ((op_reg == FUNC_LOOKUP) || (op_reg == FUNC_REMOVE)))
                begin
                    hit_next = 1'b1;
                end
                if (first_hit && (op_reg == FUNC_LOOKUP))
                begin
                    fkind_next  = head.kind;
                    fstart_next = head.start;
                    ftime_next  = head.timeout;
                end
                if ((op_reg == FUNC_EXPIRE) && drop)
                begin
                    expc_next = expc_reg + CNT_W'(1);
                end
                if (left_reg == CNT_W'(1))
                begin
                    st_next   = ST_IDLE;
                    done_next = 1'b1;
                    ok_next   = (op_reg == FUNC_EXPIRE) || hit_next;
                    entc_next = count_next;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        now_reg    <= now_next;
        ok_reg     <= ok_next;
        fkind_reg  <= fkind_next;
        fstart_reg <= fstart_next;
        ftime_reg  <= ftime_next;
        expc_reg   <= expc_next;
        entc_reg   <= entc_next;
    end

    assign busy           = (st_reg == ST_SCAN);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign found_kind     = fkind_reg;
    assign found_start_ms = fstart_reg;
    assign found_limit_ms = ftime_reg;
    assign purged_count   = expc_reg;
    assign entry_count    = entc_reg;

    assign word_take   = start && !busy;
    assign reply_total = {1'b0, expc_reg} + {1'b0, entc_reg};

    `QTT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `QTT_ASSERT_IMP(a_no_done_in_scan, clk, rst_n, st_reg == ST_SCAN, !done_reg)
    `QTT_ASSERT_NXT(a_insert_one_cycle, clk, rst_n, word_take && (func == FUNC_INSERT), done_reg)
    `QTT_ASSERT_IMP(a_result_sum, clk, rst_n, done_reg, reply_total <= (CNT_W + 1)'(TABLE_DEPTH))

endmodule

@@ bench/qtt_table_checker.sv @@
// result checker for query_timeout_table_core: keeps a shadow table of the
// pending queries, predicts the reply to each accepted word and compares it
// depends on qtt_pkg
module qtt_table_checker
    import qtt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        func,
    input  logic [63:0]       req_id,
    input  logic [3:0]        query_kind,
    input  logic [63:0]       start_ms,
    input  logic [31:0]       limit_ms,
    input  logic [63:0]       now_ms,
    input  logic              done,
    input  logic              ok,
    input  logic [3:0]        found_kind,
    input  logic [63:0]       found_start_ms,
    input  logic [31:0]       found_limit_ms,
    input  logic [CNT_W-1:0]  purged_count,
    input  logic [CNT_W-1:0]  entry_count,
    output int                error_count,
    output int                outstanding,
    output int                replies_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             ok;
        logic [3:0]       kind;
        logic [63:0]      start;
        logic [31:0]      timeout;
        logic [CNT_W-1:0] expired;
        logic [CNT_W-1:0] entries;
    } table_reply_t;

    // shadow of the table, oldest entry at index 0
    logic [63:0] id_tbl      [DEPTH];
    logic [3:0]  kind_tbl    [DEPTH];
    logic [63:0] start_tbl   [DEPTH];
    logic [31:0] timeout_tbl [DEPTH];
    int          fill = 0;

    table_reply_t expected_replies [$];
    int errs = 0;
    int pend = 0;
    int seen = 0;

    assign error_count     = errs;
    assign outstanding     = pend;
    assign replies_checked = seen;

    function automatic void move_entry(int dst, int src);
        id_tbl[dst]      = id_tbl[src];
        kind_tbl[dst]    = kind_tbl[src];
        start_tbl[dst]   = start_tbl[src];
        timeout_tbl[dst] = timeout_tbl[src];
    endfunction

    function automatic table_reply_t apply_table_op(
        logic [1:0] op, logic [63:0] id, logic [3:0] kind,
        logic [63:0] st, logic [31:0] tmo, logic [63:0] now);
        table_reply_t r;
        logic hit;
        int pos;
        int w;
        r = '0;
        hit = 1'b0;
        pos = 0;
        w = 0;
        if (op != FUNC_INSERT && op != FUNC_EXPIRE) begin
            for (int i = 0; i < fill; i++) begin
                if (!hit && id_tbl[i] == id) begin
                    hit = 1'b1;
                    pos = i;
                end
            end
        end
        case (op)
            FUNC_INSERT: begin
                if (fill < DEPTH) begin
                    id_tbl[fill]      = id;
                    kind_tbl[fill]    = kind;
                    start_tbl[fill]   = st;
                    timeout_tbl[fill] = tmo;
                    fill++;
                    r.ok = 1'b1;
                end
            end
            FUNC_LOOKUP: begin
                if (hit) begin
                    r.ok      = 1'b1;
                    r.kind    = kind_tbl[pos];
                    r.start   = start_tbl[pos];
                    r.timeout = timeout_tbl[pos];
                end
            end
            FUNC_REMOVE: begin
                if (hit) begin
                    for (int i = pos; i + 1 < fill; i++)
                        move_entry(i, i + 1);
                    fill--;
                    r.ok = 1'b1;
                end
            end
            default: begin
                // 65-bit deadline: a sum past 64 bits can never be exceeded
                for (int i = 0; i < fill; i++) begin
                    if ({1'b0, now} > ({1'b0, start_tbl[i]} + {33'b0, timeout_tbl[i]}))
                        r.expired++;
                    else
                    begin
                        if (w != i)
                            move_entry(w, i);
                        w++;
                    end
                end
                fill = w;
                r.ok = 1'b1;
            end
        endcase
        r.entries = CNT_W'(fill);
        return r;
    endfunction

    task automatic note_failure(string msg);
        errs++;
        if (errs <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        table_reply_t got;
        table_reply_t want;
        if (rst_n) begin
            // the reply of the previous word can land in the cycle a new word is taken
            if (done) begin
                got = '{ok, found_kind, found_start_ms, found_limit_ms,
                        purged_count, entry_count};
                if (expected_replies.size() == 0)
                    note_failure("result word with no word outstanding");
                else
                begin
                    want = expected_replies.pop_front();
                    seen++;
                    if (got.ok !== want.ok || got.kind !== want.kind ||
                        got.start !== want.start || got.timeout !== want.timeout ||
                        got.expired !== want.expired || got.entries !== want.entries)
                        note_failure($sformatf({"mismatch on result %0d: ",
                            "exp ok=%0b kind=%0h start=%0h timeout=%0h expired=%0d ",
                            "entries=%0d, got ok=%0b kind=%0h start=%0h timeout=%0h ",
                            "expired=%0d entries=%0d"}, seen,
                            want.ok, want.kind, want.start, want.timeout, want.expired,
                            want.entries, got.ok, got.kind, got.start, got.timeout,
                            got.expired, got.entries));
                end
            end
            if (start && !busy)
                expected_replies.push_back(apply_table_op(func, req_id, query_kind,
                                                          start_ms, limit_ms, now_ms));
            pend = expected_replies.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// top of the query timeout table bench: clock, reset and word stimulus
// depends on qtt_pkg, query_timeout_table_core and qtt_table_checker
module tb_top;
    import qtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W = $clog2(TABLE_DEPTH_DEF + 1);

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        func;
    logic [63:0]       req_id;
    logic [3:0]        query_kind;
    logic [63:0]       start_ms;
    logic [31:0]       limit_ms;
    logic [63:0]       now_ms;
    logic              done;
    logic              ok;
    logic [3:0]        found_kind;
    logic [63:0]       found_start_ms;
    logic [31:0]       found_limit_ms;
    logic [CNT_W-1:0]  purged_count;
    logic [CNT_W-1:0]  entry_count;
    int                error_count;
    int                outstanding;
    int                replies_checked;

    int          ops_issued [4] = '{0, 0, 0, 0};
    int          idle_pct = 0;
    logic [63:0] id_pool [12];
    logic [63:0] clock_ms;

    always #4 clk = ~clk;

    query_timeout_table_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .req_id         (req_id),
        .query_kind     (query_kind),
        .start_ms       (start_ms),
        .limit_ms       (limit_ms),
        .now_ms         (now_ms),
        .done           (done),
        .ok             (ok),
        .found_kind     (found_kind),
        .found_start_ms (found_start_ms),
        .found_limit_ms (found_limit_ms),
        .purged_count   (purged_count),
        .entry_count    (entry_count)
    );

    qtt_table_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .req_id          (req_id),
        .query_kind      (query_kind),
        .start_ms        (start_ms),
        .limit_ms        (limit_ms),
        .now_ms          (now_ms),
        .done            (done),
        .ok              (ok),
        .found_kind      (found_kind),
        .found_start_ms  (found_start_ms),
        .found_limit_ms  (found_limit_ms),
        .purged_count    (purged_count),
        .entry_count     (entry_count),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .replies_checked (replies_checked)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic issue_word(logic [1:0] op, logic [63:0] id, logic [3:0] kind,
                              logic [63:0] st, logic [31:0] tmo, logic [63:0] now);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        func       <= op;
        req_id     <= id;
        query_kind <= kind;
        start_ms   <= st;
        limit_ms   <= tmo;
        now_ms     <= now;
        ops_issued[op]++;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic run_directed();
        // empty table
        issue_word(FUNC_LOOKUP, 64'd0, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_REMOVE, '1, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_EXPIRE, rand64(), 4'($urandom), rand64(), $urandom, '1);
        // extremes and a duplicate id
        issue_word(FUNC_INSERT, 64'd0, 4'd0, 64'd0, 32'd0, rand64());
        issue_word(FUNC_INSERT, '1, 4'hF, '1, '1, rand64());
        issue_word(FUNC_INSERT, 64'd5, 4'd3, 64'd100, 32'd50, rand64());
        issue_word(FUNC_INSERT, 64'd5, 4'd7, 64'd200, 32'd10, rand64());
        issue_word(FUNC_LOOKUP, 64'd5, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_LOOKUP, '1, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_LOOKUP, 64'd0, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_LOOKUP, 64'd6, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_REMOVE, 64'd6, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_REMOVE, 64'd5, 4'($urandom), rand64(), $urandom, rand64());
        issue_word(FUNC_LOOKUP, 64'd5, 4'($urandom), rand64(), $urandom, rand64());
        // deadline boundaries: equal is still alive, one past is gone
        issue_word(FUNC_EXPIRE, rand64(), 4'($urandom), rand64(), $urandom, 64'd150);
        issue_word(FUNC_EXPIRE, rand64(), 4'($urandom), rand64(), $urandom, 64'd210);
        issue_word(FUNC_EXPIRE, rand64(), 4'($urandom), rand64(), $urandom, 64'd211);
        // deadlines at the top of the 64-bit range, one of them past it
        issue_word(FUNC_INSERT, 64'd9, 4'd1, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF,
                   rand64());
        issue_word(FUNC_INSERT, 64'd10, 4'd2, 64'hFFFF_FFFF_0000_0001, 32'hFFFF_FFFF,
                   rand64());
        issue_word(FUNC_INSERT, 64'd11, 4'd4, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFE,
                   rand64());
        issue_word(FUNC_EXPIRE, rand64(), 4'($urandom), rand64(), $urandom, '1);
        issue_word(FUNC_REMOVE, '1, 4'($urandom), rand64(), $urandom, rand64());
    endtask

    task automatic run_random(int count, int gap_pct);
        int insert_pct;
        int roll;
        logic [1:0]  op;
        logic [63:0] id;
        logic [63:0] st;
        logic [31:0] tmo;
        logic [63:0] now;
        insert_pct = 50;
        idle_pct = gap_pct;
        for (int n = 0; n < count; n++) begin
            // bursts that fill the table and bursts that drain it
            if (n % 40 == 0)
                case ($urandom_range(3))
                    0: insert_pct = 15;
                    1: insert_pct = 40;
                    2: insert_pct = 55;
                    default: insert_pct = 85;
                endcase
            roll = $urandom_range(99);
            if (roll < insert_pct)
                op = FUNC_INSERT;
            else
            begin
                roll = $urandom_range(9);
                op = (roll < 4) ? FUNC_LOOKUP : (roll < 7) ? FUNC_REMOVE : FUNC_EXPIRE;
            end
            id = ($urandom_range(3) != 0) ? id_pool[$urandom_range(11)] : rand64();
            if (op == FUNC_INSERT && $urandom_range(9) == 0)
                id_pool[$urandom_range(11)] = id;
            case ($urandom_range(19))
                0, 1: st = rand64();
                2: st = {32'hFFFF_FFFF, $urandom};
                default: st = clock_ms - $urandom_range(50);
            endcase
            tmo = ($urandom_range(4) == 0) ? $urandom : $urandom_range(300);
            case ($urandom_range(19))
                0: now = rand64();
                1: now = '1;
                2: now = clock_ms - $urandom_range(20);
                default: now = clock_ms + $urandom_range(200);
            endcase
            clock_ms += $urandom_range(40);
            issue_word(op, id, 4'($urandom), st, tmo, now);
        end
    endtask

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = FUNC_INSERT;
        req_id     = '0;
        query_kind = '0;
        start_ms   = '0;
        limit_ms   = '0;
        now_ms     = '0;
        for (int i = 0; i < 12; i++)
            id_pool[i] = rand64();
        id_pool[0] = '0;
        id_pool[1] = '1;
        clock_ms = rand64() >> 2;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(450, 37);
        run_random(450, 76);
        run_random(450, 0);
        start <= 1'b0;

        for (int k = 0; k < 400 && outstanding != 0; k++)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d words: %0d inserts, %0d lookups, %0d removes, %0d expires",
                 ops_issued.sum(),
                 ops_issued[FUNC_INSERT], ops_issued[FUNC_LOOKUP],
                 ops_issued[FUNC_REMOVE], ops_issued[FUNC_EXPIRE]);
        $display("compared %0d result words, %0d still outstanding, %0d failures",
                 replies_checked, outstanding, error_count);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
